### hw/rtl/servo_status_packet_parser_defines.svh
// Assertion macros shared by the servo status packet parser RTL.
`ifndef SERVO_STATUS_PACKET_PARSER_DEFINES_SVH
`define SERVO_STATUS_PACKET_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is high.
`define SSPP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sspp assertion failed");
// Clocked check that also holds during reset.
`define SSPP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sspp assertion failed");
`else
`define SSPP_ASSERT(label, clk, rst, prop)
`define SSPP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### hw/rtl/sspp_pkg.sv
// Types and constants of the servo status packet parser.
package sspp_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 1'd1;

  localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd100;
  localparam logic [7:0] MAX_LENGTH_RST    = 8'd32;
  localparam logic [7:0] MIN_LENGTH        = 8'd2;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HDR0 = 3'd1,
    PH_HDR1 = 3'd2,
    PH_ID   = 3'd3,
    PH_LEN  = 3'd4,
    PH_ERR  = 3'd5,
    PH_PARM = 3'd6,
    PH_SUM  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HDR_TO  = 3'd1,
    ST_BODY_TO = 3'd2,
    ST_BADLEN  = 3'd3,
    ST_CSUM    = 3'd4,
    ST_IDMIS   = 3'd5,
    ST_SERR    = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [7:0] expected_id;
  } item_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  param_byte;
    logic [7:0]  param_index;
    logic [2:0]  status;
    logic [7:0]  resp_id;
    logic [7:0]  servo_error;
    logic [15:0] value_word;
    logic        last;
  } result_t;

endpackage

### hw/rtl/sspp_req_if.sv
// Request channel: start, received byte or wait tick items.
interface sspp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [7:0] expected_id;

  modport source (output valid, req_type, rx_byte, expected_id, input ready);
  modport sink (input valid, req_type, rx_byte, expected_id, output ready);
endinterface

### hw/rtl/sspp_res_if.sv
// Result channel: parameter bytes and final packet status.
interface sspp_res_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [7:0]  param_byte;
  logic [7:0]  param_index;
  logic [2:0]  status;
  logic [7:0]  resp_id;
  logic [7:0]  servo_error;
  logic [15:0] value_word;
  logic        last;

  modport source (output valid, is_status, param_byte, param_index, status, resp_id,
                  servo_error, value_word, last, input ready);
  modport sink (input valid, is_status, param_byte, param_index, status, resp_id,
                servo_error, value_word, last, output ready);
endinterface

### hw/rtl/servo_status_packet_parser.sv
// Servo status packet parser top level: input stage, engine, result stage.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, rx_byte, expected_id
//   res      out  valid/ready   is_status, param_byte, param_index, status,
//                               resp_id, servo_error, value_word, last
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// One item per cycle sustained while the result register is not stalled.
// Items pass an input register, the engine's state update, then a result register.
// A stalled result register holds the input register, which then drops req.ready.
// Reset (rst, synchronous) idles the parser and restores the register defaults.
`include "servo_status_packet_parser_defines.svh"

module servo_status_packet_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sspp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sspp_pkg::CFG_DATA_W-1:0]  cfg_data,
  sspp_req_if.sink                         req,
  sspp_res_if.source                       res
);
  import sspp_pkg::*;

  logic [7:0] timeout_limit;
  logic [7:0] max_length;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;

  logic    advance;
  logic    fire;
  logic    has_res;
  result_t res_c;

  assign advance   = !out_valid || res.ready;
  assign fire      = in_valid && advance;
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_LIMIT_RST;
      max_length    <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        CFG_MAX_LENGTH:    max_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.req_type    <= req.req_type;
      in_item.rx_byte     <= req.rx_byte;
      in_item.expected_id <= req.expected_id;
    end
  end

  sspp_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (in_item),
    .timeout_limit (timeout_limit),
    .max_length    (max_length),
    .has_res       (has_res),
    .res           (res_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      out_res <= res_c;
    end
  end

  assign res.valid       = out_valid;
  assign res.is_status   = out_res.is_status;
  assign res.param_byte  = out_res.param_byte;
  assign res.param_index = out_res.param_index;
  assign res.status      = out_res.status;
  assign res.resp_id     = out_res.resp_id;
  assign res.servo_error = out_res.servo_error;
  assign res.value_word  = out_res.value_word;
  assign res.last        = out_res.last;

  `SSPP_ASSERT(a_in_held_on_stall, clk, rst, in_valid && !advance |=> in_valid)
  `SSPP_ASSERT(a_out_held_on_stall, clk, rst, out_valid && !res.ready |=> out_valid)
  `SSPP_ASSERT_ALWAYS(a_no_fire_in_reset, clk, rst |=> !out_valid)

endmodule

### hw/rtl/sspp_engine.sv
// Packet state machine: one item per fire, at most one result per item.
`include "servo_status_packet_parser_defines.svh"

module sspp_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  sspp_pkg::item_t item,
  input  logic [7:0]      timeout_limit,
  input  logic [7:0]      max_length,
  output logic            has_res,
  output sspp_pkg::result_t res
);
  import sspp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  wait_count, wait_count_next;
  logic [7:0]  want_id, want_id_next;
  logic [7:0]  got_id, got_id_next;
  logic [7:0]  pkt_length, pkt_length_next;
  logic [7:0]  err_byte, err_byte_next;
  logic [7:0]  params_left, params_left_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] first_two_params, first_two_params_next;

  logic [7:0] b;
  logic [7:0] param_idx;
  logic       len_bad;
  logic       tick_to;
  logic       in_header;

  assign b         = item.rx_byte;
  assign param_idx = (pkt_length - MIN_LENGTH) - params_left;
  assign len_bad   = (b < MIN_LENGTH) || (b > max_length);
  // wait_count + 1 > limit
  assign tick_to   = (wait_count >= timeout_limit);
  assign in_header = (phase <= PH_LEN);

  // next state
  always_comb begin
    phase_next            = phase;
    wait_count_next       = wait_count;
    want_id_next          = want_id;
    got_id_next           = got_id;
    pkt_length_next       = pkt_length;
    err_byte_next         = err_byte;
    params_left_next      = params_left;
    running_sum_next      = running_sum;
    first_two_params_next = first_two_params;
    if (fire) begin
      unique case (item.req_type)
        REQ_START: begin
          want_id_next          = item.expected_id;
          phase_next            = PH_HDR0;
          wait_count_next       = '0;
          got_id_next           = '0;
          pkt_length_next       = '0;
          err_byte_next         = '0;
          params_left_next      = '0;
          running_sum_next      = '0;
          first_two_params_next = '0;
        end
        REQ_BYTE: begin
          unique case (phase)
            PH_IDLE: ;
            PH_HDR0: phase_next = PH_HDR1;
            PH_HDR1: phase_next = PH_ID;
            PH_ID: begin
              got_id_next      = b;
              running_sum_next = running_sum + b;
              phase_next       = PH_LEN;
            end
            PH_LEN: begin
              pkt_length_next = b;
              if (len_bad) begin
                phase_next = PH_IDLE;
              end else begin
                running_sum_next = running_sum + b;
                params_left_next = b - MIN_LENGTH;
                wait_count_next  = '0;
                phase_next       = PH_ERR;
              end
            end
            PH_ERR: begin
              err_byte_next    = b;
              running_sum_next = running_sum + b;
              phase_next       = (params_left != '0) ? PH_PARM : PH_SUM;
            end
            PH_PARM: begin
              if (param_idx == 8'd0) begin
                first_two_params_next[7:0] = b;
              end else if (param_idx == 8'd1) begin
                first_two_params_next[15:8] = b;
              end
              running_sum_next = running_sum + b;
              params_left_next = params_left - 8'd1;
              if (params_left == 8'd1) begin
                phase_next = PH_SUM;
              end
            end
            PH_SUM: phase_next = PH_IDLE;
            default: ;
          endcase
        end
        REQ_TICK: begin
          if (phase != PH_IDLE) begin
            if (tick_to) begin
              phase_next = PH_IDLE;
            end else begin
              wait_count_next = wait_count + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result
  always_comb begin
    has_res         = 1'b0;
    res             = '0;
    res.resp_id     = got_id;
    res.servo_error = err_byte;
    res.value_word  = first_two_params;
    res.is_status   = 1'b1;
    res.last        = 1'b1;
    res.status      = ST_OK;
    if (fire) begin
      unique case (item.req_type)
        REQ_BYTE: begin
          unique case (phase)
            PH_LEN: begin
              has_res    = len_bad;
              res.status = ST_BADLEN;
            end
            PH_PARM: begin
              has_res = 1'b1;
              res     = '0;
              res.param_byte  = b;
              res.param_index = param_idx;
            end
            PH_SUM: begin
              has_res = 1'b1;
              priority if (~running_sum != b) begin
                res.status = ST_CSUM;
              end else if (got_id != want_id) begin
                res.status = ST_IDMIS;
              end else if (err_byte != '0) begin
                res.status = ST_SERR;
              end else begin
                res.status = ST_OK;
              end
            end
            default: ;
          endcase
        end
        REQ_TICK: begin
          has_res    = (phase != PH_IDLE) && tick_to;
          res.status = in_header ? ST_HDR_TO : ST_BODY_TO;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      wait_count       <= '0;
      want_id          <= '0;
      got_id           <= '0;
      pkt_length       <= '0;
      err_byte         <= '0;
      params_left      <= '0;
      running_sum      <= '0;
      first_two_params <= '0;
    end else begin
      phase            <= phase_next;
      wait_count       <= wait_count_next;
      want_id          <= want_id_next;
      got_id           <= got_id_next;
      pkt_length       <= pkt_length_next;
      err_byte         <= err_byte_next;
      params_left      <= params_left_next;
      running_sum      <= running_sum_next;
      first_two_params <= first_two_params_next;
    end
  end

  `SSPP_ASSERT(a_status_closes, clk, rst, has_res && res.is_status |=> phase == PH_IDLE)
  `SSPP_ASSERT(a_param_in_body, clk, rst, has_res && !res.is_status |-> phase == PH_PARM)
  `SSPP_ASSERT(a_idle_silent, clk, rst, fire && phase == PH_IDLE |-> !has_res)
  `SSPP_ASSERT(a_parm_has_left, clk, rst, phase == PH_PARM |-> params_left != 8'd0)

endmodule

### bench/tb_servo_status_packet_parser.sv
// Self-checking bench for the servo status packet parser: directed table, then random packets.
module tb_servo_status_packet_parser;
  import sspp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 270;
  localparam int NUM_PHASES = 8;

  typedef struct {
    bit         is_cfg;  // register row: b is timeout limit, id is max length
    logic [1:0] kind;
    logic [7:0] b;
    logic [7:0] id;
    bit         pinned;
    result_t    res;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sspp_req_if req_bus ();
  sspp_res_if res_bus ();

  servo_status_packet_parser dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_bus.sink),
    .res(res_bus.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser state as predicted
  phase_t      ph;
  logic [7:0]  tick_count, want_id, got_id, pkt_len, err_b, params_left, byte_sum;
  logic [15:0] word;
  logic [7:0]  lim_now, cap_now;
  result_t     pending_results[$];
  int          fails = 0;

  // stimulus side
  step_t      script[$];
  bit         pin_on;
  result_t    pin_res;
  logic [7:0] lim_cur, cap_cur;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         items_sent = 0;
  bit         hold_go = 1'b0;
  bit         hold_rx = 1'b0;

  logic [7:0] lim_plan [NUM_PHASES] = '{8'd100, 8'd0, 8'd255, 8'd5, 8'd1, 8'd40, 8'd255, 8'd0};
  logic [7:0] cap_plan [NUM_PHASES] = '{8'd32, 8'd2, 8'd255, 8'd8, 8'd3, 8'd20, 8'd2, 8'd255};

  function automatic string show(result_t r);
    return $sformatf(
      "is_status=%0d status=%0d byte=%02h idx=%0d id=%02h err=%02h word=%04h last=%0d",
      r.is_status, r.status, r.param_byte, r.param_index, r.resp_id,
      r.servo_error, r.value_word, r.last);
  endfunction

  task automatic finish_packet(input status_t s, output result_t r);
    r = '0;
    r.is_status = 1'b1;
    r.status = s;
    r.resp_id = got_id;
    r.servo_error = err_b;
    r.value_word = word;
    r.last = 1'b1;
    ph = PH_IDLE;
  endtask

  task automatic advance_parser(input item_t it, output bit produced, output result_t r);
    logic [7:0] b, idx;
    b = it.rx_byte;
    produced = 1'b0;
    r = '0;
    case (it.req_type)
      REQ_START: begin
        // a start always rearms, even mid-packet
        want_id = it.expected_id;
        ph = PH_HDR0;
        tick_count = '0;
        got_id = '0;
        pkt_len = '0;
        err_b = '0;
        params_left = '0;
        byte_sum = '0;
        word = '0;
      end
      REQ_BYTE: begin
        case (ph)
          PH_HDR0: ph = PH_HDR1;
          PH_HDR1: ph = PH_ID;
          PH_ID: begin
            got_id = b;
            byte_sum += b;
            ph = PH_LEN;
          end
          PH_LEN: begin
            pkt_len = b;
            if (b < MIN_LENGTH || b > cap_now) begin
              finish_packet(ST_BADLEN, r);
              produced = 1'b1;
            end else begin
              byte_sum += b;
              params_left = b - MIN_LENGTH;
              tick_count = '0;
              ph = PH_ERR;
            end
          end
          PH_ERR: begin
            err_b = b;
            byte_sum += b;
            ph = (params_left != 8'd0) ? PH_PARM : PH_SUM;
          end
          PH_PARM: begin
            idx = pkt_len - MIN_LENGTH - params_left;
            if (idx == 8'd0) word[7:0] = b;
            else if (idx == 8'd1) word[15:8] = b;
            byte_sum += b;
            params_left -= 8'd1;
            if (params_left == 8'd0) ph = PH_SUM;
            r.param_byte = b;
            r.param_index = idx;
            produced = 1'b1;
          end
          PH_SUM: begin
            // checksum wins over id, id over servo error
            if (~byte_sum != b) finish_packet(ST_CSUM, r);
            else if (got_id != want_id) finish_packet(ST_IDMIS, r);
            else if (err_b != 8'd0) finish_packet(ST_SERR, r);
            else finish_packet(ST_OK, r);
            produced = 1'b1;
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (ph != PH_IDLE) begin
          if ({1'b0, tick_count} + 9'd1 > {1'b0, lim_now}) begin
            finish_packet((ph <= PH_LEN) ? ST_HDR_TO : ST_BODY_TO, r);
            produced = 1'b1;
          end else begin
            tick_count += 8'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    item_t   it;
    result_t want, got;
    bit      produced;
    if (rst) begin
      ph = PH_IDLE;
      tick_count = '0;
      want_id = '0;
      got_id = '0;
      pkt_len = '0;
      err_b = '0;
      params_left = '0;
      byte_sum = '0;
      word = '0;
      lim_now = TIMEOUT_LIMIT_RST;
      cap_now = MAX_LENGTH_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT_LIMIT) lim_now = cfg_data;
        else if (cfg_index == CFG_MAX_LENGTH) cap_now = cfg_data;
      end
      if (req_bus.valid && req_bus.ready) begin
        it = {req_bus.req_type, req_bus.rx_byte, req_bus.expected_id};
        advance_parser(it, produced, want);
        if (produced) pending_results.push_back(pin_on ? pin_res : want);
      end
      if (res_bus.valid && res_bus.ready) begin
        got = {res_bus.is_status, res_bus.param_byte, res_bus.param_index, res_bus.status,
               res_bus.resp_id, res_bus.servo_error, res_bus.value_word, res_bus.last};
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch:\n  expected %s\n  actual   %s", show(want), show(got));
          end
        end
      end
    end
  end

  initial begin : receiver
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_bus.ready = !hold_rx && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the parser backs up and drops req.ready
  initial begin : backpressure
    wait (hold_go);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin : watchdog
    #4000000;
    $display("FAIL servo_status_packet_parser");
    $finish;
  end

  function automatic void add_step(input logic [1:0] kind, input logic [7:0] b,
                                   input logic [7:0] id);
    script.push_back('{is_cfg: 1'b0, kind: kind, b: b, id: id, pinned: 1'b0, res: '0});
  endfunction

  function automatic void add_closing(input logic [1:0] kind, input logic [7:0] b,
                                      input logic [7:0] id, input status_t s,
                                      input logic [7:0] rid, input logic [7:0] err,
                                      input logic [15:0] w);
    result_t r;
    r = '0;
    r.is_status = 1'b1;
    r.status = s;
    r.resp_id = rid;
    r.servo_error = err;
    r.value_word = w;
    r.last = 1'b1;
    script.push_back('{is_cfg: 1'b0, kind: kind, b: b, id: id, pinned: 1'b1, res: r});
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic put_item(input logic [1:0] kind, input logic [7:0] b, input logic [7:0] id,
                          input bit pin, input result_t pres);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid = 1'b1;
    req_bus.req_type = kind;
    req_bus.rx_byte = b;
    req_bus.expected_id = id;
    pin_on = pin;
    pin_res = pres;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic put(input logic [1:0] kind, input logic [7:0] b, input logic [7:0] id);
    put_item(kind, b, id, 1'b0, '0);
  endtask

  task automatic settle();
    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] lim, input logic [7:0] cap);
    cfg_we = 1'b1;
    cfg_index = CFG_TIMEOUT_LIMIT;
    cfg_data = lim;
    @(negedge clk);
    cfg_index = CFG_MAX_LENGTH;
    cfg_data = cap;
    @(negedge clk);
    cfg_we = 1'b0;
    lim_cur = lim;
    cap_cur = cap;
  endtask

  task automatic tick_gap();
    int r, n;
    n = 0;
    r = $urandom_range(99);
    if (r >= 98) n = $urandom_range(int'(lim_cur) + 1);
    else if (r >= 75) n = $urandom_range(3, 1);
    repeat (n) put(REQ_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(3, 1))
      put(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_packet();
    logic [7:0] id, len, b, sum;
    int r, cut;
    id = 8'($urandom_range(255));
    put(REQ_START, 8'($urandom_range(255)), id);
    tick_gap();
    repeat (2) begin
      put(REQ_BYTE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      tick_gap();
    end
    b = ($urandom_range(99) < 85) ? id : 8'($urandom_range(255));
    put(REQ_BYTE, b, 8'($urandom_range(255)));
    sum = b;
    tick_gap();
    r = $urandom_range(99);
    if (r < 5)
      len = (cap_cur == 8'hFF || r < 2) ? 8'($urandom_range(1))
                                        : 8'($urandom_range(255, int'(cap_cur) + 1));
    else if (r < 7)
      len = cap_cur;
    else
      len = 8'($urandom_range((cap_cur < 8'd12) ? int'(cap_cur) : 12, 2));
    put(REQ_BYTE, len, 8'($urandom_range(255)));
    if (len < MIN_LENGTH || len > cap_cur) return;
    sum += len;
    tick_gap();
    // occasionally cut the packet short; the next start drops it
    cut = ($urandom_range(99) < 8) ? int'($urandom_range(int'(len) - 2)) : -1;
    b = ($urandom_range(99) < 80) ? 8'h00 : 8'($urandom_range(255));
    put(REQ_BYTE, b, 8'($urandom_range(255)));
    sum += b;
    for (int i = 0; i < int'(len) - 2; i++) begin
      if (i == cut) return;
      tick_gap();
      b = 8'($urandom_range(255));
      put(REQ_BYTE, b, 8'($urandom_range(255)));
      sum += b;
    end
    if (cut == int'(len) - 2) return;
    tick_gap();
    put(REQ_BYTE, ($urandom_range(99) < 85) ? ~sum : 8'($urandom_range(255)),
        8'($urandom_range(255)));
  endtask

  initial begin : stimulus
    step_t s;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_START;
    req_bus.rx_byte = '0;
    req_bus.expected_id = '0;
    pin_on = 1'b0;
    pin_res = '0;
    lim_cur = TIMEOUT_LIMIT_RST;
    cap_cur = MAX_LENGTH_RST;

    // idle parser ignores bytes, ticks and the unused code
    add_step(REQ_BYTE, 8'hFF, 8'h00);
    add_step(REQ_TICK, 8'h00, 8'h00);
    add_step(REQ_UNUSED, 8'hFF, 8'hFF);
    // clean packet at reset settings, two parameters
    add_step(REQ_START, 8'h00, 8'hFE);
    add_step(REQ_BYTE, 8'hFF, 8'h00);
    add_step(REQ_BYTE, 8'hFF, 8'h00);
    add_step(REQ_BYTE, 8'hFE, 8'h00);
    add_step(REQ_BYTE, 8'h04, 8'h00);
    add_step(REQ_BYTE, 8'h00, 8'h00);
    add_step(REQ_BYTE, 8'h34, 8'h00);
    add_step(REQ_BYTE, 8'h12, 8'h00);
    add_closing(REQ_BYTE, 8'hB7, 8'h00, ST_OK, 8'hFE, 8'h00, 16'h1234);
    // length one above the reset max length
    add_step(REQ_START, 8'h00, 8'h01);
    add_step(REQ_BYTE, 8'h00, 8'h00);
    add_step(REQ_BYTE, 8'h00, 8'h00);
    add_step(REQ_BYTE, 8'h01, 8'h00);
    add_closing(REQ_BYTE, 8'h21, 8'h00, ST_BADLEN, 8'h01, 8'h00, 16'h0000);
    script.push_back('{is_cfg: 1'b1, kind: REQ_START, b: 8'd0, id: 8'd255, pinned: 1'b0,
                       res: '0});
    // restart while busy, then length zero
    add_step(REQ_START, 8'h00, 8'h05);
    add_step(REQ_BYTE, 8'h00, 8'h00);
    add_step(REQ_START, 8'h00, 8'h05);
    add_step(REQ_BYTE, 8'h00, 8'h00);
    add_step(REQ_BYTE, 8'h00, 8'h00);
    add_step(REQ_BYTE, 8'h05, 8'h00);
    add_closing(REQ_BYTE, 8'h00, 8'h00, ST_BADLEN, 8'h05, 8'h00, 16'h0000);
    // zero timeout limit: first tick times out
    add_step(REQ_START, 8'hFF, 8'h07);
    add_closing(REQ_TICK, 8'h00, 8'h00, ST_HDR_TO, 8'h00, 8'h00, 16'h0000);

    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      s = script[i];
      if (s.is_cfg) begin
        settle();
        set_regs(s.b, s.id);
      end else begin
        put_item(s.kind, s.b, s.id, s.pinned, s.res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_regs(lim_plan[p], cap_plan[p]);
      send_idle_pct = (p % 4 == 1) ? 54 : (p % 4 == 3) ? 11 : 0;
      stall_pct = (p % 4 == 2) ? 54 : (p % 4 == 3) ? 11 : 0;
      if (p == 4) hold_go = 1'b1;
      while (items_sent < (p + 1) * PHASE_ITEMS) begin
        if ($urandom_range(99) < 10) send_noise();
        send_packet();
      end
    end

    settle();
    if (fails == 0)
      $display("PASS servo_status_packet_parser");
    else
      $display("FAIL servo_status_packet_parser");
    $finish;
  end

endmodule

### servo_status_packet_parser.f
+incdir+hw/rtl
hw/rtl/sspp_pkg.sv
hw/rtl/sspp_req_if.sv
hw/rtl/sspp_res_if.sv
hw/rtl/sspp_engine.sv
hw/rtl/servo_status_packet_parser.sv
bench/tb_servo_status_packet_parser.sv
